/* rtl/pvm_pkg.sv */
// Shared types and constants of the PCM voice mixer.
`default_nettype none
package pvm_pkg;
  localparam int MaxVoices   = 16;
  localparam int NumTypes    = 16;
  localparam int SampleDepth = 4096;
  localparam int DelayBits   = 11;
  localparam int SlotW  = $clog2(MaxVoices);
  localparam int CntW   = $clog2(MaxVoices + 1);
  localparam int TypeW  = 4;
  localparam int AddrW  = $clog2(SampleDepth);
  localparam int LenW   = AddrW + 1;
  localparam int PosW   = (LenW > DelayBits ? LenW : DelayBits) + 1;
  localparam int StoreW = TypeW + AddrW;
  localparam int SumW   = 8 + CntW + 2;
  localparam logic [7:0] MidLevel = 8'd128;

  typedef enum logic [2:0] {
    OpTick = 3'd0, OpStart = 3'd1, OpStopType = 3'd2,
    OpStopAll = 3'd3, OpWrite = 3'd4, OpLength = 3'd5,
    OpNop6 = 3'd6, OpNop7 = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StFull = 2'd1, StNoSample = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SIdle, STickRead, STickAcc, SStealScan, SStealDrop, SStart,
    SStopScan, SStopAll, SCompact, SDone
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // capture the input beat
    logic       clr_scan;   // scan pointer to zero
    logic       scan_inc;
    logic       tick_read;  // issue store read for slot at scan
    logic       tick_acc;   // accumulate / advance / mark retire
    logic       steal_eval; // compare slot at scan for steal
    logic       steal_mark; // mark picked slot for removal
    logic       start_push;
    logic       stop_mark;  // mark slot at scan if same type
    logic       stop_all;
    logic       compact;    // shift one marked slot out
    logic       write_cfg;  // write / length ops, stop-type count clear
    logic       finish;     // load output register
    logic       set_full;
    logic       set_nosample;
  } cmd_t;

  typedef struct packed {
    op_e        op;
    logic       scan_end;   // scan pointer reached live count
    logic       len_zero;   // length of addressed type is zero
    logic       at_limit;   // steal due
    logic       table_full;
    logic       any_marked;
  } stat_t;
endpackage
`default_nettype wire

/* rtl/pcm_voice_mixer_with_stealing.sv */
// Top level of the polyphonic PCM voice mixer with voice stealing.
// A tick reads and accumulates each live voice, then shifts out the retired ones; a
// start may scan for a voice to steal and drop it, then adds the voice; a stop by
// type scans and shifts out the removed voices; stop all clears the table at once.
// One beat at a time: the next is taken in the cycle after the result loads.
// Reset clears voice table, counts and lengths; store kept, max_same_type back to 3.
`default_nettype none
module pcm_voice_mixer_with_stealing (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [3:0]  sound_type_i,
  input  wire logic [10:0] start_delay_i,
  input  wire logic [11:0] sample_address_i,
  input  wire logic [7:0]  sample_byte_i,
  input  wire logic [12:0] sample_length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       mixed_sample_o,
  output logic [4:0]       type_in_use_o,
  output logic [1:0]       status_o
);
  pvm_pkg::cmd_t  cmd;
  pvm_pkg::stat_t st;
  logic [3:0]     max_q;
  logic           ov_q;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {28'd0, max_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 4'd3;
      ov_q  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) max_q <= pwdata[3:0];
      if (cmd.finish) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end
  assign out_valid_o = ov_q;

  pvm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i (ov_q && out_stall_i),
    .st_i (st), .cmd_o (cmd)
  );

  pvm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .st_o (st),
    .opcode_i, .sound_type_i, .start_delay_i, .sample_address_i,
    .sample_byte_i, .sample_length_i, .max_same_type_i (max_q),
    .mixed_sample_o, .type_in_use_o, .status_o
  );
endmodule
`default_nettype wire

/* rtl/pvm_ctrl.sv */
// Controller state machine of the PCM voice mixer.
`default_nettype none
module pvm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           out_busy_i,
  input  wire pvm_pkg::stat_t st_i,
  output pvm_pkg::cmd_t       cmd_o
);
  pvm_pkg::state_e state_q, state_d;

  assign in_stall_o = (state_q != pvm_pkg::SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pvm_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pvm_pkg::SIdle: begin
        if (in_valid_i) state_d = pvm_pkg::SDone;
        if (in_valid_i) begin
          case (st_i.op)
            pvm_pkg::OpTick:     state_d = pvm_pkg::STickRead;
            pvm_pkg::OpStart:    state_d = pvm_pkg::SStealScan;
            pvm_pkg::OpStopType: state_d = pvm_pkg::SStopScan;
            pvm_pkg::OpStopAll:  state_d = pvm_pkg::SStopAll;
            default:             state_d = pvm_pkg::SDone;
          endcase
        end
      end
      pvm_pkg::STickRead: state_d = st_i.scan_end ? pvm_pkg::SCompact : pvm_pkg::STickAcc;
      pvm_pkg::STickAcc:  state_d = pvm_pkg::STickRead;
      pvm_pkg::SStealScan: begin
        if (st_i.len_zero || !st_i.at_limit) state_d = pvm_pkg::SStart;
        else if (st_i.scan_end) state_d = pvm_pkg::SStealDrop;
      end
      pvm_pkg::SStealDrop: state_d = st_i.any_marked ? pvm_pkg::SStealDrop : pvm_pkg::SStart;
      pvm_pkg::SStart:     state_d = pvm_pkg::SDone;
      pvm_pkg::SStopScan:  state_d = st_i.scan_end ? pvm_pkg::SCompact : pvm_pkg::SStopScan;
      pvm_pkg::SStopAll:   state_d = pvm_pkg::SDone;
      pvm_pkg::SCompact:   state_d = st_i.any_marked ? pvm_pkg::SCompact : pvm_pkg::SDone;
      pvm_pkg::SDone:      state_d = out_busy_i ? pvm_pkg::SDone : pvm_pkg::SIdle;
      default:             state_d = pvm_pkg::SIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      pvm_pkg::SIdle: begin
        cmd_o.load     = in_valid_i;
        cmd_o.clr_scan = 1'b1;
      end
      pvm_pkg::STickRead: cmd_o.tick_read = !st_i.scan_end;
      pvm_pkg::STickAcc: begin
        cmd_o.tick_acc = 1'b1;
        cmd_o.scan_inc = 1'b1;
      end
      pvm_pkg::SStealScan: begin
        if (st_i.len_zero) begin
          cmd_o.set_nosample = 1'b1;
        end else if (st_i.at_limit) begin
          if (st_i.scan_end) cmd_o.steal_mark = 1'b1;
          else begin
            cmd_o.steal_eval = 1'b1;
            cmd_o.scan_inc   = 1'b1;
          end
        end
      end
      pvm_pkg::SStealDrop: cmd_o.compact = st_i.any_marked;
      pvm_pkg::SStart: begin
        if (!st_i.len_zero) begin
          if (st_i.table_full) cmd_o.set_full = 1'b1;
          else cmd_o.start_push = 1'b1;
        end
      end
      pvm_pkg::SStopScan: begin
        if (!st_i.scan_end) begin
          cmd_o.stop_mark = 1'b1;
          cmd_o.scan_inc  = 1'b1;
        end
      end
      pvm_pkg::SStopAll: cmd_o.stop_all = 1'b1;
      pvm_pkg::SCompact: cmd_o.compact = st_i.any_marked;
      pvm_pkg::SDone: begin
        cmd_o.finish    = !out_busy_i;
        cmd_o.write_cfg = !out_busy_i;
      end
      default: cmd_o = '0;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/pvm_datapath.sv */
// Datapath of the PCM voice mixer: voice table, counts, lengths, sample store, mix.
`default_nettype none
module pvm_datapath (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire pvm_pkg::cmd_t            cmd_i,
  output pvm_pkg::stat_t                st_o,
  input  wire logic [2:0]               opcode_i,
  input  wire logic [3:0]               sound_type_i,
  input  wire logic [10:0]              start_delay_i,
  input  wire logic [11:0]              sample_address_i,
  input  wire logic [7:0]               sample_byte_i,
  input  wire logic [12:0]              sample_length_i,
  input  wire logic [3:0]               max_same_type_i,
  output logic [7:0]                    mixed_sample_o,
  output logic [4:0]                    type_in_use_o,
  output logic [1:0]                    status_o
);
  localparam int MV = pvm_pkg::MaxVoices;
  localparam int NT = pvm_pkg::NumTypes;

  logic [2:0]                 op_q;
  logic [3:0]                 typ_q;
  logic [10:0]                dly_q;
  logic [11:0]                addr_q;
  logic [7:0]                 byte_q;
  logic [12:0]                len_q;

  logic [MV-1:0]              mark_q;
  logic [3:0]                 vtype_q [MV];
  logic signed [pvm_pkg::PosW-1:0] vpos_q [MV];
  logic [pvm_pkg::CntW-1:0]   tcnt_q [NT];
  logic [pvm_pkg::LenW-1:0]   tlen_q [NT];
  logic [pvm_pkg::CntW-1:0]   live_q;
  logic [pvm_pkg::CntW-1:0]   scan_q;
  logic [pvm_pkg::CntW-1:0]   n_q;        // type count at start entry
  logic [7:0]                 store_mem [2**pvm_pkg::StoreW];
  logic [7:0]                 rd_q;
  logic                       snd_q;      // slot being read sounds
  logic signed [pvm_pkg::SumW-1:0] sum_q;
  logic                       pick_q;
  logic [pvm_pkg::SlotW-1:0]  pick_idx_q;
  logic signed [pvm_pkg::PosW-1:0] best_q;
  logic [1:0]                 stat_q;
  logic [7:0]                 mix_q;
  logic [4:0]                 use_q;

  logic [pvm_pkg::SlotW-1:0]  si;
  logic [3:0]                 st;
  logic signed [pvm_pkg::PosW-1:0] sp;
  logic [pvm_pkg::LenW-1:0]   sl;
  logic                       alive;
  logic [pvm_pkg::SlotW-1:0]  first_mark;
  logic [pvm_pkg::CntW-1:0]   lim;
  logic signed [pvm_pkg::SumW-1:0] mix_full;

  assign si    = scan_q[pvm_pkg::SlotW-1:0];
  assign st    = vtype_q[si];
  assign sp    = vpos_q[si];
  assign sl    = tlen_q[st];
  assign alive = (sl != '0) && (sp < $signed({1'b0, sl}));
  assign lim   = (max_same_type_i == 4'd0) ? pvm_pkg::CntW'(1)
                                           : pvm_pkg::CntW'(max_same_type_i);

  always_comb begin
    first_mark = '0;
    for (int k = MV - 1; k >= 0; k--) begin
      if (mark_q[k]) first_mark = pvm_pkg::SlotW'(k);
    end
  end

  assign st_o.op         = pvm_pkg::op_e'(opcode_i);
  assign st_o.scan_end   = (scan_q >= live_q);
  assign st_o.len_zero   = (tlen_q[typ_q] == '0);
  assign st_o.at_limit   = (n_q >= lim) && (n_q != '0);
  assign st_o.table_full = (live_q >= pvm_pkg::CntW'(MV));
  assign st_o.any_marked = |mark_q;

  assign mix_full = sum_q + $signed(pvm_pkg::SumW'(pvm_pkg::MidLevel));

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_read) begin
      rd_q <= store_mem[{st, sp[pvm_pkg::AddrW-1:0]}];
    end
    if (cmd_i.write_cfg && op_q == pvm_pkg::OpWrite) begin
      store_mem[{typ_q, addr_q}] <= byte_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q     <= '0;
      live_q     <= '0;
      scan_q     <= '0;
      pick_q     <= 1'b0;
      op_q       <= '0;
      typ_q      <= '0;
      dly_q      <= '0;
      addr_q     <= '0;
      byte_q     <= '0;
      len_q      <= '0;
      n_q        <= '0;
      sum_q      <= '0;
      stat_q     <= pvm_pkg::StOk;
      pick_idx_q <= '0;
      best_q     <= '0;
      snd_q      <= 1'b0;
      for (int k = 0; k < MV; k++) begin
        vtype_q[k] <= '0;
        vpos_q[k]  <= '0;
      end
      for (int k = 0; k < NT; k++) begin
        tcnt_q[k] <= '0;
        tlen_q[k] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        op_q   <= opcode_i;
        typ_q  <= sound_type_i;
        dly_q  <= start_delay_i;
        addr_q <= sample_address_i;
        byte_q <= sample_byte_i;
        len_q  <= sample_length_i;
        n_q    <= tcnt_q[sound_type_i];
        sum_q  <= '0;
        stat_q <= pvm_pkg::StOk;
        pick_q <= 1'b0;
        mark_q <= '0;
      end
      if (cmd_i.clr_scan) scan_q <= '0;
      if (cmd_i.scan_inc) scan_q <= scan_q + 1'b1;
      if (cmd_i.tick_read) snd_q <= alive && !sp[pvm_pkg::PosW-1];
      if (cmd_i.tick_acc) begin
        if (alive) begin
          vpos_q[si] <= sp + 1'b1;
          if (snd_q) sum_q <= sum_q + $signed(pvm_pkg::SumW'(rd_q)) -
                              $signed(pvm_pkg::SumW'(pvm_pkg::MidLevel));
        end else begin
          mark_q[si] <= 1'b1;
          if (tcnt_q[st] != '0) tcnt_q[st] <= tcnt_q[st] - 1'b1;
        end
      end
      if (cmd_i.steal_eval && st == typ_q && (!pick_q || sp > best_q)) begin
        pick_q     <= 1'b1;
        pick_idx_q <= si;
        best_q     <= sp;
      end
      if (cmd_i.steal_mark && pick_q) begin
        mark_q[pick_idx_q] <= 1'b1;
        tcnt_q[typ_q]      <= tcnt_q[typ_q] - 1'b1;
      end
      if (cmd_i.stop_mark && st == typ_q) mark_q[si] <= 1'b1;
      if (cmd_i.compact) begin
        // Shift every slot above the lowest marked one down by one.
        for (int k = 0; k < MV - 1; k++) begin
          if (k >= first_mark) begin
            vtype_q[k] <= vtype_q[k+1];
            vpos_q[k]  <= vpos_q[k+1];
            mark_q[k]  <= mark_q[k+1];
          end
        end
        vtype_q[MV-1] <= '0;
        vpos_q[MV-1]  <= '0;
        mark_q[MV-1]  <= 1'b0;
        live_q        <= live_q - 1'b1;
      end
      if (cmd_i.start_push) begin
        vtype_q[live_q[pvm_pkg::SlotW-1:0]] <= typ_q;
        vpos_q[live_q[pvm_pkg::SlotW-1:0]]  <= (n_q != '0) ?
            -$signed(pvm_pkg::PosW'(dly_q[pvm_pkg::DelayBits-1:0])) : '0;
        live_q        <= live_q + 1'b1;
        tcnt_q[typ_q] <= tcnt_q[typ_q] + 1'b1;
      end
      if (cmd_i.set_full)     stat_q <= pvm_pkg::StFull;
      if (cmd_i.set_nosample) stat_q <= pvm_pkg::StNoSample;
      if (cmd_i.stop_all) begin
        live_q <= '0;
        for (int k = 0; k < MV; k++) begin
          vtype_q[k] <= '0;
          vpos_q[k]  <= '0;
        end
        for (int k = 0; k < NT; k++) tcnt_q[k] <= '0;
      end
      if (cmd_i.write_cfg && op_q == pvm_pkg::OpStopType) tcnt_q[typ_q] <= '0;
      if (cmd_i.write_cfg && op_q == pvm_pkg::OpLength) begin
        tlen_q[typ_q] <= (len_q > 13'(pvm_pkg::SampleDepth)) ?
                         pvm_pkg::LenW'(pvm_pkg::SampleDepth) : len_q[pvm_pkg::LenW-1:0];
      end
    end
  end

  // Output register; count is taken after this beat's last table update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (op_q == pvm_pkg::OpTick) begin
        if (mix_full < 0) mix_q <= 8'd0;
        else if (mix_full > 255) mix_q <= 8'd255;
        else mix_q <= mix_full[7:0];
      end else begin
        mix_q <= pvm_pkg::MidLevel;
      end
      if (op_q == pvm_pkg::OpStopType) use_q <= '0;
      else if (op_q == pvm_pkg::OpStopAll) use_q <= '0;
      else use_q <= 5'(tcnt_q[typ_q]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) status_o <= stat_q;
  end

  assign mixed_sample_o = mix_q;
  assign type_in_use_o  = use_q;
endmodule
`default_nettype wire

/* rtl/pvm_checker.sv */
// Port-level checker of the PCM voice mixer, bound to the top level.
`default_nettype none
module pvm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] mixed_sample_o,
  input wire logic [1:0] status_o,
  input wire logic [4:0] type_in_use_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mixed_sample_o))
    else $error("stalled result beat changed");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat taken while busy");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3 && type_in_use_o <= 5'd16)
    else $error("result beat out of range");
  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 2'd0 |-> mixed_sample_o == 8'd128)
    else $error("non-tick beat without mid level");
endmodule

bind pcm_voice_mixer_with_stealing pvm_checker u_chk (.*);
`default_nettype wire
